// ===== rtl/core/assert_macros.svh =====
// Assertion helpers; the using module supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define ASSERT_NEXT(label, trig, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expr)) \
		else $error(msg);

`endif

// ===== rtl/core/svp_pkg.sv =====
package svp_pkg;

	localparam int STORE_WORDS_DEF   = 65536;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int FRAME_W           = 17;
	localparam int SAMPLE_W          = 16;
	localparam int CODE_W            = 8;
	localparam int STEP_W            = 24;
	localparam int CFG_DATA_W        = 24;
	localparam int CFG_INDEX_W       = 3;
	localparam int RECIP_SHIFT       = 39;

	localparam logic [FRAME_W-1:0] MAX_FRAMES = 17'd65536;
	localparam logic [CODE_W-1:0]  CODE_FULL  = 8'd255;
	localparam logic [STEP_W-1:0]  STEP_RESET = 24'd65536;
	// ceil(2^39 / 255): exact floor division by 255 for any 32-bit dividend
	localparam logic [31:0]        RECIP_255  = 32'h80808081;

	localparam logic [1:0] LOOP_FORWARD   = 2'd1;
	localparam logic [1:0] LOOP_PING_PONG = 2'd2;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_NOTE_ON,
		OP_TICK,
		OP_KILL
	} opcode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_FRAME_COUNT,
		CFG_STEREO,
		CFG_START_CODE,
		CFG_END_CODE,
		CFG_LOOP_MODE,
		CFG_STEP
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NOTE0,
		ST_NOTE1,
		ST_NOTE2,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_RD4,
		ST_MUL_L,
		ST_ADD_L,
		ST_MUL_R,
		ST_ADD_R,
		ST_ADV,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

// ===== rtl/core/svp_store.sv =====
module svp_store #(
	parameter int DEPTH = svp_pkg::STORE_WORDS_DEF
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(DEPTH)-1:0]      waddr,
	input  logic [svp_pkg::SAMPLE_W-1:0]  wdata,
	input  logic [$clog2(DEPTH)-1:0]      raddr,
	output logic [svp_pkg::SAMPLE_W-1:0]  rdata
);
	import svp_pkg::*;

	logic [SAMPLE_W-1:0] mem_q [DEPTH];
	logic [SAMPLE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/svp_rem.sv =====
`include "assert_macros.svh"

// Restoring remainder, one dividend bit per cycle.
module svp_rem #(
	parameter int W = 34
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] rem
);
	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0]     r_q;
	logic [W-1:0]     m_q;
	logic [W-1:0]     d_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [W-1:0]     trial;

	// remainder stays below the divisor, so the top bit is free for the shift
	assign trial = {r_q[W-2:0], m_q[W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			r_q    <= '0;
			m_q    <= '0;
			d_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
				r_q    <= '0;
				m_q    <= dividend;
				d_q    <= divisor;
			end else if (busy_q) begin
				r_q   <= (trial >= d_q) ? trial - d_q : trial;
				m_q   <= m_q << 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = r_q;

	`ASSERT_NEXT(a_start_busy, start, busy_q, "remainder unit did not start")
	`ASSERT_ALWAYS(a_rem_below, !done_q || (r_q < d_q), "remainder not below divisor")

endmodule

// ===== rtl/core/sample_playback_voice_top.sv =====
// Load, kill and config writes take effect in the cycle they are taken. Note-on: NOTE0,
// NOTE1, NOTE2, or back to idle after NOTE0 when there is no sample. Tick: store reads in
// RD0-RD4, MUL/ADD left then right, ADV, then the result is registered in OUT; an inactive
// tick goes straight to OUT. A wrap or reflection through the remainder unit adds ST_DIV.
// One item at a time; the next is taken once the current result sits in the output register.
// arst_n clears control, config and voice state; payload registers and store contents stay undefined.
`include "assert_macros.svh"

module sample_playback_voice_top #(
	parameter int STORE_WORDS   = svp_pkg::STORE_WORDS_DEF,
	parameter int FRACTION_BITS = svp_pkg::FRACTION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [svp_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [svp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        opcode,
	input  logic [15:0]                       address,
	input  logic signed [15:0]                value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [15:0]                left_sample,
	output logic signed [15:0]                right_sample,
	output logic                              still_active
);
	import svp_pkg::*;

	localparam int AW    = $clog2(STORE_WORDS);
	localparam int FB    = FRACTION_BITS;
	localparam int PW    = FRAME_W + FB;
	localparam int SW    = PW + 2;
	localparam int PRODW = SAMPLE_W + 2 + FB;
	localparam logic [SW-1:0]           ONE_FRAME = SW'(1) << FB;
	localparam logic signed [PRODW-1:0] HALF      = PRODW'(1) << (FB - 1);

	// configuration
	logic [FRAME_W-1:0] frame_count_q;
	logic               stereo_q;
	logic [CODE_W-1:0]  start_code_q;
	logic [CODE_W-1:0]  end_code_q;
	logic [1:0]         loop_mode_q;
	logic [STEP_W-1:0]  step_q;

	// voice state
	state_t             state_q, state_d;
	logic [PW-1:0]      pos_q;
	logic               backward_q;
	logic [FRAME_W-1:0] first_q;
	logic [FRAME_W-1:0] wend_q;
	logic               voice_on_q;

	// working registers
	logic [CODE_W+FRAME_W-1:0] prod255_q;
	logic [FRAME_W-1:0]        sf_q;
	logic [FRAME_W-1:0]        ef_q;
	logic signed [SAMPLE_W-1:0] a_l_q, b_l_q, a_r_q, b_r_q;
	logic signed [PRODW-1:0]   prod_q;
	logic signed [SAMPLE_W-1:0] res_l_q, res_r_q;
	logic                      res_act_q;
	logic                      neg_q, over_q;
	logic [SW-1:0]             den_q;

	// output register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] left_q, right_q;
	logic                       active_q;

	// store port
	logic          st_we;
	logic [AW-1:0] st_raddr;
	logic [SAMPLE_W-1:0] st_rdata;

	// remainder unit
	logic          div_start;
	logic          div_done;
	logic [SW-1:0] div_rem;

	function automatic logic [AW-1:0] word_addr(logic [FRAME_W-1:0] frame, logic st,
			logic chan);
		logic [FRAME_W:0] w;
		w = st ? {frame, chan} : {1'b0, frame};
		return AW'(w);
	endfunction

	// note-on arithmetic
	logic [FRAME_W-1:0] fc;
	logic [CODE_W+FRAME_W:0] ef_prod;
	logic [CODE_W+FRAME_W+31:0] recip_prod;
	logic               rev;
	logic [FRAME_W:0]   n_first, n_wend;
	logic [FRAME_W-1:0] n_start;

	always_comb begin
		fc         = (frame_count_q > MAX_FRAMES) ? MAX_FRAMES : frame_count_q;
		ef_prod    = (CODE_W+FRAME_W+1)'({1'b0, end_code_q} + 9'd1) * (CODE_W+FRAME_W+1)'(fc);
		recip_prod = (CODE_W+FRAME_W+32)'(prod255_q) * (CODE_W+FRAME_W+32)'(RECIP_255);
		rev        = start_code_q > end_code_q;
		n_first    = rev ? {1'b0, ef_q} - 1'b1 : {1'b0, sf_q};
		n_wend     = rev ? {1'b0, sf_q} + 1'b1 : {1'b0, ef_q};
		if (n_wend <= n_first) begin
			n_wend = n_first + 1'b1;
		end
		if (n_wend > {1'b0, fc}) begin
			n_wend = {1'b0, fc};
		end
		n_start = rev ? FRAME_W'(n_wend - 1'b1) : FRAME_W'(n_first);
	end

	// tick addressing
	logic [FRAME_W-1:0] frame, other;
	logic [FB-1:0]      frac;

	always_comb begin
		frame = pos_q[PW-1:FB];
		frac  = pos_q[FB-1:0];
		if (!backward_q) begin
			other = ({1'b0, frame} + 1'b1 < {1'b0, wend_q}) ? frame + 1'b1 : frame;
		end else begin
			other = (frame > first_q) ? frame - 1'b1 : frame;
		end
	end

	// interpolation
	logic signed [SAMPLE_W-1:0] mul_a, mul_b;
	logic signed [SAMPLE_W:0]   diff;
	logic signed [PRODW-1:0]    t_sum, t_shift;
	logic signed [SAMPLE_W-1:0] interp;

	always_comb begin
		mul_a   = (state_q == ST_MUL_L || state_q == ST_ADD_L) ? a_l_q : a_r_q;
		mul_b   = (state_q == ST_MUL_L || state_q == ST_ADD_L) ? b_l_q : b_r_q;
		diff    = $signed({mul_b[SAMPLE_W-1], mul_b}) - $signed({mul_a[SAMPLE_W-1], mul_a});
		t_sum   = prod_q + HALF;
		t_shift = t_sum >>> FB;
		interp  = mul_a + t_shift[SAMPLE_W-1:0];
	end

	// position advance
	logic signed [SW-1:0] lo_s, hi_s, last_s, span_s, len_s, pos_s, step_s, p_s, x_s;
	logic [SW-1:0]        mag;
	logic                 in_win;
	logic [SW-1:0]        r_adj, wrap_pos;

	always_comb begin
		lo_s   = $signed(SW'({first_q, {FB{1'b0}}}));
		hi_s   = $signed(SW'({wend_q, {FB{1'b0}}}));
		last_s = hi_s - $signed(ONE_FRAME);
		span_s = last_s - lo_s;
		len_s  = hi_s - lo_s;
		pos_s  = $signed(SW'(pos_q));
		step_s = $signed(SW'(step_q));
		p_s    = backward_q ? pos_s - step_s : pos_s + step_s;
		x_s    = p_s - lo_s;
		mag    = x_s[SW-1] ? SW'(-x_s) : SW'(x_s);
		in_win = (p_s >= lo_s) && (p_s < hi_s);
		r_adj  = (neg_q && div_rem != '0) ? den_q - div_rem : div_rem;
		if (loop_mode_q == LOOP_FORWARD || r_adj <= SW'(span_s)) begin
			wrap_pos = SW'(lo_s) + r_adj;
		end else begin
			wrap_pos = SW'(lo_s) + den_q - r_adj;
		end
	end

	// control
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		st_raddr  = word_addr(frame, stereo_q, 1'b0);
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (opcode_t'(opcode))
						OP_NOTE_ON: state_d = ST_NOTE0;
						OP_TICK:    state_d = voice_on_q ? ST_RD0 : ST_OUT;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_NOTE0: state_d = (fc == '0) ? ST_IDLE : ST_NOTE1;
			ST_NOTE1: state_d = ST_NOTE2;
			ST_NOTE2: state_d = ST_IDLE;
			ST_RD0:   state_d = ST_RD1;
			ST_RD1: begin
				st_raddr = word_addr(other, stereo_q, 1'b0);
				state_d  = ST_RD2;
			end
			ST_RD2: begin
				st_raddr = word_addr(frame, stereo_q, 1'b1);
				state_d  = ST_RD3;
			end
			ST_RD3: begin
				st_raddr = word_addr(other, stereo_q, 1'b1);
				state_d  = ST_RD4;
			end
			ST_RD4:   state_d = ST_MUL_L;
			ST_MUL_L: state_d = ST_ADD_L;
			ST_ADD_L: state_d = ST_MUL_R;
			ST_MUL_R: state_d = ST_ADD_R;
			ST_ADD_R: state_d = ST_ADV;
			ST_ADV: begin
				state_d = ST_OUT;
				if (!in_win) begin
					if (loop_mode_q == LOOP_FORWARD
							|| (loop_mode_q == LOOP_PING_PONG && span_s != '0)) begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
				end
			end
			ST_DIV:   state_d = div_done ? ST_OUT : ST_DIV;
			ST_OUT:   state_d = (!out_valid_q || out_ready) ? ST_IDLE : ST_OUT;
			default:  state_d = ST_IDLE;
		endcase
	end

	assign st_we = (state_q == ST_IDLE) && in_valid && (opcode_t'(opcode) == OP_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			frame_count_q <= '0;
			stereo_q      <= 1'b0;
			start_code_q  <= '0;
			end_code_q    <= CODE_FULL;
			loop_mode_q   <= '0;
			step_q        <= STEP_RESET;
			pos_q         <= '0;
			backward_q    <= 1'b0;
			first_q       <= '0;
			wend_q        <= '0;
			voice_on_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					CFG_FRAME_COUNT: frame_count_q <= cfg_data[FRAME_W-1:0];
					CFG_STEREO:      stereo_q      <= cfg_data[0];
					CFG_START_CODE:  start_code_q  <= cfg_data[CODE_W-1:0];
					CFG_END_CODE:    end_code_q    <= cfg_data[CODE_W-1:0];
					CFG_LOOP_MODE:   loop_mode_q   <= cfg_data[1:0];
					CFG_STEP:        step_q        <= cfg_data[STEP_W-1:0];
					default:         ;
				endcase
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && opcode_t'(opcode) == OP_KILL) begin
						voice_on_q <= 1'b0;
					end
				end
				ST_NOTE0: begin
					if (fc == '0) begin
						voice_on_q <= 1'b0;
					end
				end
				ST_NOTE2: begin
					if (rev && ef_q == '0) begin
						voice_on_q <= 1'b0;
					end else begin
						first_q    <= FRAME_W'(n_first);
						wend_q     <= FRAME_W'(n_wend);
						backward_q <= rev;
						pos_q      <= {n_start, {FB{1'b0}}};
						voice_on_q <= 1'b1;
					end
				end
				ST_ADV: begin
					if (in_win) begin
						pos_q <= PW'(p_s);
					end else if (loop_mode_q == LOOP_PING_PONG) begin
						backward_q <= over_q ^ over_q ^ (p_s > last_s);
						if (span_s == '0) begin
							pos_q <= PW'(lo_s);
						end
					end else if (loop_mode_q != LOOP_FORWARD) begin
						voice_on_q <= 1'b0;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						pos_q <= PW'(wrap_pos);
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				res_l_q   <= '0;
				res_r_q   <= '0;
				res_act_q <= 1'b0;
			end
			ST_NOTE0: begin
				prod255_q <= (CODE_W+FRAME_W)'(start_code_q) * (CODE_W+FRAME_W)'(fc - 1'b1);
				ef_q      <= (end_code_q == CODE_FULL) ? fc : FRAME_W'(ef_prod >> 8);
			end
			ST_NOTE1: sf_q <= FRAME_W'(recip_prod >> RECIP_SHIFT);
			ST_RD1:   a_l_q <= $signed(st_rdata);
			ST_RD2:   b_l_q <= $signed(st_rdata);
			ST_RD3:   a_r_q <= $signed(st_rdata);
			ST_RD4:   b_r_q <= $signed(st_rdata);
			ST_MUL_L, ST_MUL_R: prod_q <= diff * $signed({1'b0, frac});
			ST_ADD_L: res_l_q <= interp;
			ST_ADD_R: res_r_q <= interp;
			ST_ADV: begin
				neg_q     <= x_s[SW-1];
				over_q    <= p_s > last_s;
				den_q     <= (loop_mode_q == LOOP_FORWARD) ? SW'(len_s) : SW'(span_s) << 1;
				res_act_q <= in_win || loop_mode_q == LOOP_FORWARD
					|| loop_mode_q == LOOP_PING_PONG;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					left_q   <= res_l_q;
					right_q  <= res_r_q;
					active_q <= res_act_q;
				end
			end
			default: ;
		endcase
	end

	// store accesses never overlap: a load is taken only in idle, reads run inside a tick
	svp_store #(
		.DEPTH (STORE_WORDS)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (AW'(address)),
		.wdata (value),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	svp_rem #(
		.W (SW)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  ((loop_mode_q == LOOP_FORWARD) ? SW'(len_s) : SW'(span_s) << 1),
		.done     (div_done),
		.rem      (div_rem)
	);

	assign out_valid    = out_valid_q;
	assign left_sample  = left_q;
	assign right_sample = right_q;
	assign still_active = active_q;

	`ASSERT_ALWAYS(a_ready_idle, !in_ready || state_q == ST_IDLE, "item taken outside idle")
	`ASSERT_ALWAYS(a_pos_in_window,
		!(voice_on_q && state_q == ST_IDLE) || (pos_s >= lo_s && pos_s < hi_s),
		"play position outside window")
	`ASSERT_ALWAYS(a_window_order, !voice_on_q || wend_q > first_q, "empty window while playing")

endmodule

// ===== dv/sample_playback_voice_checker.sv =====
`timescale 1ns / 1ps

module sample_playback_voice_checker
	import svp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic [15:0]        address,
	input  logic signed [15:0] value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] left_sample,
	input  logic signed [15:0] right_sample,
	input  logic               still_active,
	output int                 fail_count,
	output int                 pending
);

	localparam longint ONE = 64'd1 << FRACTION_BITS_DEF;

	typedef struct {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic               active;
	} voice_out_t;

	voice_out_t expected_voice_q[$];

	logic [15:0] pcm_store [0:STORE_WORDS_DEF-1];

	longint      pos;
	bit          backward;
	int unsigned win_first, win_end;
	bit          playing;

	int unsigned frames_r, stereo_r, start_r, end_r, loop_r, step_r;

	assign pending = expected_voice_q.size();

	task automatic report(input string what, input int got, input int want);
		$display("%0t: %s got %0d expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	function automatic int word_at(input int unsigned frame, input int unsigned chan);
		int unsigned idx;
		idx = (frame * (stereo_r ? 2 : 1) + (stereo_r ? chan : 0)) % STORE_WORDS_DEF;
		return $signed(pcm_store[idx]);
	endfunction

	function automatic int lerp(input int unsigned chan);
		int unsigned frame, other;
		longint frac, t;
		int a, b;
		frame = int'(pos >> FRACTION_BITS_DEF);
		frac  = pos & (ONE - 1);
		if (!backward)
			other = (frame + 1 < win_end) ? frame + 1 : frame;
		else
			other = (frame > win_first) ? frame - 1 : frame;
		a = word_at(frame, chan);
		b = word_at(other, chan);
		t = longint'(b - a) * frac + (ONE >> 1) + (longint'(65536) << FRACTION_BITS_DEF);
		return a + int'((t >> FRACTION_BITS_DEF) - 65536);
	endfunction

	function automatic void move_on();
		longint lo, hi, p, len, r, last, span, period;
		bit over;
		lo = longint'(win_first) << FRACTION_BITS_DEF;
		hi = longint'(win_end) << FRACTION_BITS_DEF;
		p  = backward ? pos - step_r : pos + step_r;
		if (p >= lo && p < hi) begin
			pos = p;
			return;
		end
		if (loop_r == LOOP_FORWARD) begin
			len = hi - lo;
			r = (p - lo) % len;
			if (r < 0)
				r += len;
			pos = lo + r;
		end else if (loop_r == LOOP_PING_PONG) begin
			last = hi - ONE;
			span = last - lo;
			over = p > last;
			if (span == 0) begin
				pos = lo;
			end else begin
				period = 2 * span;
				r = (p - lo) % period;
				if (r < 0)
					r += period;
				pos = (r <= span) ? lo + r : lo + period - r;
			end
			backward = over;
		end else begin
			playing = 0;
		end
	endfunction

	function automatic void start_note();
		int unsigned fc, sf, ef, first, wend;
		bit rev;
		fc = (frames_r > 65536) ? 65536 : frames_r;
		if (fc == 0) begin
			playing = 0;
			return;
		end
		sf  = start_r * (fc - 1) / 255;
		ef  = (end_r == 255) ? fc : (end_r + 1) * fc / 256;
		rev = start_r > end_r;
		if (rev) begin
			if (ef == 0) begin
				playing = 0;
				return;
			end
			first = ef - 1;
			wend  = sf + 1;
		end else begin
			first = sf;
			wend  = ef;
		end
		if (wend <= first)
			wend = first + 1;
		if (wend > fc)
			wend = fc;
		win_first = first;
		win_end   = wend;
		backward  = rev;
		pos       = longint'(rev ? wend - 1 : first) << FRACTION_BITS_DEF;
		playing   = 1;
	endfunction

	function automatic voice_out_t tick_result();
		voice_out_t v;
		v = '{left: '0, right: '0, active: 1'b0};
		if (playing) begin
			v.left  = 16'(lerp(0));
			v.right = 16'(lerp(1));
			move_on();
			v.active = playing;
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		voice_out_t want;
		if (!arst_n) begin
			fail_count = 0;
			expected_voice_q.delete();
			pos = 0;
			backward = 0;
			win_first = 0;
			win_end = 0;
			playing = 0;
			frames_r = 0;
			stereo_r = 0;
			start_r = 0;
			end_r = 255;
			loop_r = 0;
			step_r = 65536;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FRAME_COUNT: frames_r = cfg_data[16:0];
					CFG_STEREO:      stereo_r = cfg_data[0];
					CFG_START_CODE:  start_r  = cfg_data[7:0];
					CFG_END_CODE:    end_r    = cfg_data[7:0];
					CFG_LOOP_MODE:   loop_r   = cfg_data[1:0];
					CFG_STEP:        step_r   = cfg_data[23:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_voice_q.size() == 0) begin
					report("unexpected result, left", left_sample, 0);
				end else begin
					want = expected_voice_q.pop_front();
					if (left_sample !== want.left)
						report("left_sample", left_sample, want.left);
					if (right_sample !== want.right)
						report("right_sample", right_sample, want.right);
					if (still_active !== want.active)
						report("still_active", still_active, want.active);
				end
			end
			if (in_valid && in_ready) begin
				case (opcode_t'(opcode))
					OP_LOAD:    pcm_store[address] = value;
					OP_NOTE_ON: start_note();
					OP_KILL:    playing = 0;
					default:    expected_voice_q.push_back(tick_result());
				endcase
			end
		end
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import svp_pkg::*;

	localparam int          RANDOM_ITEMS = 950;
	localparam int          DRAIN_CYCLES = 64;
	localparam int          CYCLE_LIMIT  = 600000;
	localparam logic [2:0]  CFG_UNUSED   = 3'd6;
	localparam logic [23:0] STEP_MAX     = 24'hFFFFFF;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_we = 0;
	logic [2:0]         cfg_index = '0;
	logic [23:0]        cfg_data = '0;
	logic               in_valid = 0;
	logic               in_ready;
	logic [1:0]         opcode = OP_TICK;
	logic [15:0]        address = '0;
	logic signed [15:0] value = '0;
	logic               out_valid;
	logic               out_ready = 0;
	logic signed [15:0] left_sample, right_sample;
	logic               still_active;
	int                 fail_count, pending;
	int                 cycles = 0;
	int                 items_sent = 0;
	bit                 idling = 1;

	always #5 clk = ~clk;

	sample_playback_voice_top u_dut (.*);

	sample_playback_voice_checker u_chk (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// out side: random back-pressure bursts
	initial begin
		forever begin
			@(negedge clk);
			if (idling && $urandom_range(0, 5) == 0) begin
				out_ready = 0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end
			out_ready = 1;
		end
	end

	task automatic send(input opcode_t op, input logic [15:0] addr, input logic [15:0] val);
		if (idling && $urandom_range(0, 5) == 0) begin
			in_valid = 0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_valid = 1;
		opcode   = op;
		address  = addr;
		value    = val;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid = 0;
		items_sent++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
		cfg_we    = 1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// note-on then ticks, or with mixed set a mix of ticks, kills, re-triggers and loads
	task automatic play(input logic [16:0] frames, input bit st, input logic [7:0] sc,
			input logic [7:0] ec, input logic [1:0] lm, input logic [23:0] step,
			input int n, input bit mixed);
		int pick;
		drain();
		write_reg(CFG_FRAME_COUNT, 24'(frames));
		write_reg(CFG_STEREO, 24'(st));
		write_reg(CFG_START_CODE, 24'(sc));
		write_reg(CFG_END_CODE, 24'(ec));
		write_reg(CFG_LOOP_MODE, 24'(lm));
		write_reg(CFG_STEP, step);
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_UNUSED | 3'($urandom_range(0, 1)), 24'($urandom));
		send(OP_NOTE_ON, 16'($urandom), 16'($urandom));
		repeat (n) begin
			pick = mixed ? $urandom_range(0, 99) : 0;
			if (pick < 70)
				send(OP_TICK, 16'($urandom), 16'($urandom));
			else if (pick < 78)
				send(OP_NOTE_ON, 16'($urandom), 16'($urandom));
			else if (pick < 83)
				send(OP_KILL, 16'($urandom), 16'($urandom));
			else
				send(OP_LOAD, 16'($urandom), 16'($urandom));
		end
	endtask

	function automatic logic [23:0] pick_step();
		case ($urandom_range(0, 5))
			0:       return 24'($urandom_range(1, 255));
			1:       return 24'($urandom_range(1, 24'hFFFFFF));
			2:       return STEP_MAX;
			default: return 24'($urandom_range(1, 24'h40000));
		endcase
	endfunction

	initial begin
		logic [16:0] frames;
		logic [7:0]  sc, ec;
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: inactive tick, note-on with no sample
		send(OP_TICK, 16'hFFFF, 16'hFFFF);
		send(OP_NOTE_ON, '0, '0);
		send(OP_TICK, '0, '0);
		// fill every word that any window below can read; extremes first
		send(OP_LOAD, 16'd0, 16'h7FFF);
		send(OP_LOAD, 16'd1, 16'h8000);
		send(OP_LOAD, 16'hFFFF, 16'h8000);
		for (int i = 2; i < 256; i++)
			send(OP_LOAD, 16'(i), 16'($urandom));

		// oversized frame count, full-length store, window in the first 256 frames
		play(17'h1FFFF, 0, 8'd0, 8'd0, LOOP_PING_PONG, 24'h1_8000, 3, 0);
		// reverse window whose end frame maps to zero
		play(17'd100, 0, 8'd10, 8'd0, 2'd0, 24'd65536, 1, 0);
		// one-frame ping-pong window pins the position
		play(17'd1, 1, 8'd0, 8'd255, LOOP_PING_PONG, 24'h3_0000, 3, 0);
		// one-shot leaving the window on the first tick
		play(17'd64, 1, 8'd0, 8'd255, 2'd0, STEP_MAX, 3, 0);
		// reverse forward-loop, and loop mode three behaves as one-shot
		play(17'd128, 1, 8'd255, 8'd0, LOOP_FORWARD, 24'd1, 2, 0);
		send(OP_KILL, '0, '0);
		send(OP_TICK, '0, '0);
		play(17'd65536, 0, 8'd0, 8'd0, 2'd3, 24'h20_0000, 3, 0);

		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent > RANDOM_ITEMS - 150)
				idling = 0;
			sc = 8'($urandom);
			ec = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom);
			case ($urandom_range(0, 9))
				0: frames = 17'd0;
				1: begin
					frames = ($urandom_range(0, 1)) ? 17'd65536 : 17'h1FFFF;
					sc = 8'd0;
					ec = 8'd0;
				end
				default: frames = 17'($urandom_range(1, 128));
			endcase
			play(frames, ($urandom_range(0, 1) == 1) && frames <= 128, sc, ec,
				2'($urandom_range(0, 3)), pick_step(), $urandom_range(10, 60), 1);
		end

		drain();
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
